[hdl/ring_pattern_window_detector_macros.svh]
// Assertion helpers shared by the checker.
`ifndef RING_PATTERN_WINDOW_DETECTOR_MACROS_SVH
`define RING_PATTERN_WINDOW_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RPWD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RPWD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rpwd_pkg.sv]
package rpwd_pkg;

    localparam int RPWD_MAX_COLS     = 64;
    localparam int RPWD_SAMPLE_WIDTH = 16;
    localparam int RPWD_ADDR_W       = 4;
    localparam int RPWD_ROW_LIMIT    = 64;

    localparam logic [6:0]         RPWD_ROWS_RST   = 7'd20;
    localparam logic [6:0]         RPWD_COLS_RST   = 7'd20;
    localparam logic signed [15:0] RPWD_CENTER_RST = 16'sd42;
    localparam logic signed [15:0] RPWD_RING_RST   = 16'sd7;

    typedef enum logic [1:0] {
        REG_GRID_ROWS = 2'd0,
        REG_GRID_COLS = 2'd1,
        REG_CENTER    = 2'd2,
        REG_RING      = 2'd3
    } reg_idx_t;

endpackage

[hdl/rpwd_ram.sv]
module rpwd_ram
    import rpwd_pkg::*;
#(
    parameter int WIDTH = RPWD_SAMPLE_WIDTH,
    parameter int DEPTH = RPWD_MAX_COLS
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-before-write on a shared address.
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/ring_pattern_window_detector.sv]
// 3x3 ring-pattern detector. Grid samples stream in raster order on the s_
// channel, one per cycle at full rate. Two line stores (one RAM each, one
// entry per column) hold the two previous rows, and a 3x3 register window
// holds the newest three columns of the last three rows. An interior cell
// matches when it holds center_value and all eight neighbors hold
// ring_value; the match is reported as 1-based (match_x, match_y) on the m_
// channel when the sample at the lower-right corner of its window arrives.
// Border cells never match. Throughput is one item per cycle while s_ready
// is high. The accepting edge captures the item in the compare stage and
// issues the registered line-store read; when that stage advances, the
// window is compared as it shifts and a hit loads the output register.
// A result may wait in the output register while the next item is taken;
// s_ready drops only when that register is full, not taken, and the
// compare stage holds an item. Registers (APB, byte address
// 4*i): 0 grid_rows, 1 grid_cols (both clamped to 1..64, zero acts as one),
// 2 center_value, 3 ring_value (signed 16 bit). Write them only while the
// block is idle. After the last sample of a frame the scan position wraps
// to row 0, column 0.
module ring_pattern_window_detector
    import rpwd_pkg::*;
#(
    parameter int MAX_COLS     = RPWD_MAX_COLS,
    parameter int SAMPLE_WIDTH = RPWD_SAMPLE_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [RPWD_ADDR_W-1:0]         paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // sample stream
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    // match stream
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [6:0]                     m_match_x,
    output logic [6:0]                     m_match_y
);

    // Column positions never reach this limit, so it sizes the line stores.
    localparam int COL_LIMIT = (MAX_COLS < 127) ? MAX_COLS : 127;
    localparam int CW        = $clog2(COL_LIMIT);
    localparam int SW        = SAMPLE_WIDTH;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [6:0]         grid_rows_reg;
    logic [6:0]         grid_cols_reg;
    logic signed [15:0] center_reg;
    logic signed [15:0] ring_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= RPWD_ROWS_RST;
            grid_cols_reg <= RPWD_COLS_RST;
            center_reg    <= RPWD_CENTER_RST;
            ring_reg      <= RPWD_RING_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_GRID_ROWS: grid_rows_reg <= pwdata[6:0];
                REG_GRID_COLS: grid_cols_reg <= pwdata[6:0];
                REG_CENTER:    center_reg    <= pwdata[15:0];
                REG_RING:      ring_reg      <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_GRID_ROWS: prdata = {25'd0, grid_rows_reg};
            REG_GRID_COLS: prdata = {25'd0, grid_cols_reg};
            REG_CENTER:    prdata = {16'd0, center_reg};
            REG_RING:      prdata = {16'd0, ring_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // Clamp the grid size; a zero size acts as one.
    logic [6:0] rows_eff;
    logic [6:0] cols_eff;

    always_comb begin
        if (grid_rows_reg == 7'd0) begin
            rows_eff = 7'd1;
        end else if (grid_rows_reg > 7'(RPWD_ROW_LIMIT)) begin
            rows_eff = 7'(RPWD_ROW_LIMIT);
        end else begin
            rows_eff = grid_rows_reg;
        end
        if (grid_cols_reg == 7'd0) begin
            cols_eff = 7'd1;
        end else if (grid_cols_reg > 7'(COL_LIMIT)) begin
            cols_eff = 7'(COL_LIMIT);
        end else begin
            cols_eff = grid_cols_reg;
        end
    end

    // Register values seen at sample width: sign-extend or truncate.
    logic signed [SW-1:0] center_val;
    logic signed [SW-1:0] ring_val;

    assign center_val = SW'(center_reg);
    assign ring_val   = SW'(ring_reg);

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic s_accept;
    logic s1_advance;
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg, m_valid_next;
    logic hit;

    // The compare stage moves on whenever the output register is free or
    // being emptied; take a new item whenever the compare stage is empty or moves on.
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Scan position of the next sample
    // ------------------------------------------------------------------
    logic [CW-1:0] col_count_reg, col_count_next;
    logic [5:0]    row_count_reg, row_count_next;
    logic          in_interior;

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (s_accept) begin
            if (8'(col_count_reg) + 8'd1 >= 8'(cols_eff)) begin
                col_count_next = '0;
                if (7'(row_count_reg) + 7'd1 >= rows_eff) begin
                    row_count_next = '0;
                end else begin
                    row_count_next = row_count_reg + 6'd1;
                end
            end else begin
                col_count_next = col_count_reg + CW'(1);
            end
        end
    end

    // Only centers whose eight neighbors lie inside the grid may match.
    assign in_interior = (8'(col_count_reg) >= 8'd2) && (row_count_reg >= 6'd2) &&
                         (8'(col_count_reg) < 8'(cols_eff)) &&
                         (7'(row_count_reg) < rows_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: read at accept, write when the compare stage advances
    // ------------------------------------------------------------------
    logic [SW-1:0]        upper_rdata;
    logic [SW-1:0]        middle_rdata;
    logic signed [SW-1:0] up_eff;
    logic signed [SW-1:0] mid_eff;

    logic signed [SW-1:0] s1_sample_reg;
    logic [CW-1:0]        s1_col_reg;
    logic [5:0]           s1_row_reg;
    logic                 s1_check_reg;
    logic                 s1_fwd_reg, s1_fwd_next;
    logic signed [SW-1:0] s1_fwd_up_reg;
    logic signed [SW-1:0] s1_fwd_mid_reg;
    logic                 s1_line_vld_reg;

    // Entries never written since reset read as zero.
    logic [COL_LIMIT-1:0] line_vld_reg, line_vld_next;

    rpwd_ram #(
        .WIDTH (SW),
        .DEPTH (COL_LIMIT)
    ) u_upper_ram (
        .clk   (aclk),
        .we    (s1_advance),
        .waddr (s1_col_reg),
        .wdata (mid_eff),
        .re    (s_accept),
        .raddr (col_count_reg),
        .rdata (upper_rdata)
    );

    rpwd_ram #(
        .WIDTH (SW),
        .DEPTH (COL_LIMIT)
    ) u_middle_ram (
        .clk   (aclk),
        .we    (s1_advance),
        .waddr (s1_col_reg),
        .wdata (s1_sample_reg),
        .re    (s_accept),
        .raddr (col_count_reg),
        .rdata (middle_rdata)
    );

    // A read that meets a write to the same column at the same edge (grid
    // one column wide) sees the old entry: bypass with the written data.
    assign s1_fwd_next = s1_valid_reg && (col_count_reg == s1_col_reg);

    always_comb begin
        if (s1_fwd_reg) begin
            up_eff  = s1_fwd_up_reg;
            mid_eff = s1_fwd_mid_reg;
        end else if (s1_line_vld_reg) begin
            up_eff  = upper_rdata;
            mid_eff = middle_rdata;
        end else begin
            up_eff  = '0;
            mid_eff = '0;
        end
    end

    always_comb begin
        line_vld_next = line_vld_reg;
        if (s1_advance) begin
            line_vld_next[s1_col_reg] = 1'b1;
        end
    end

    assign s1_valid_next = s_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            line_vld_reg <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            line_vld_reg <= line_vld_next;
        end
    end

    // Capture the item and its bypass data at accept.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_sample_reg   <= s_sample;
            s1_col_reg      <= col_count_reg;
            s1_row_reg      <= row_count_reg;
            s1_check_reg    <= in_interior;
            s1_fwd_reg      <= s1_fwd_next;
            s1_fwd_up_reg   <= mid_eff;
            s1_fwd_mid_reg  <= s1_sample_reg;
            s1_line_vld_reg <= line_vld_reg[col_count_reg];
        end
    end

    // ------------------------------------------------------------------
    // 3x3 window: shift left, load the new column, compare
    // ------------------------------------------------------------------
    logic signed [SW-1:0] win_reg [9];
    logic signed [SW-1:0] win_next [9];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[k*3 + 0] = win_reg[k*3 + 1];
            win_next[k*3 + 1] = win_reg[k*3 + 2];
        end
        win_next[2] = up_eff;
        win_next[5] = mid_eff;
        win_next[8] = s1_sample_reg;
    end

    always_comb begin
        hit = s1_check_reg && (win_next[4] == center_val);
        for (int k = 0; k < 9; k++) begin
            if (k != 4 && win_next[k] != ring_val) begin
                hit = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else if (s1_advance) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [6:0] match_x_reg;
    logic [6:0] match_y_reg;

    // Load on a hit, drop once taken, hold otherwise.
    assign m_valid_next = (s1_advance && hit) ? 1'b1 :
                          (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && hit) begin
            match_x_reg <= 7'(s1_col_reg);
            match_y_reg <= 7'(s1_row_reg);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_match_x = match_x_reg;
    assign m_match_y = match_y_reg;

endmodule

[hdl/rpwd_checker.sv]
`include "ring_pattern_window_detector_macros.svh"

module rpwd_checker
    import rpwd_pkg::*;
#(
    parameter int MAX_COLS = RPWD_MAX_COLS
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_match_x,
    input logic [6:0] m_match_y
);

    localparam int COL_LIMIT = (MAX_COLS < 127) ? MAX_COLS : 127;

    // A stalled result holds.
    `RPWD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_match_x) && $stable(m_match_y), "stalled result changed")

    // Only interior centers are reported.
    `RPWD_ASSERT_NOW(a_interior, aclk, aresetn, m_valid,
        (m_match_x >= 7'd2) && (m_match_y >= 7'd2) &&
        (m_match_x < 7'(COL_LIMIT)) && (m_match_y < 7'(RPWD_ROW_LIMIT)),
        "match outside the grid interior")

    // With the output register empty the input side never stalls.
    `RPWD_ASSERT_NOW(a_no_bubble, aclk, aresetn, !m_valid, s_ready,
        "input stalled with empty output")

endmodule

bind ring_pattern_window_detector rpwd_checker #(
    .MAX_COLS (MAX_COLS)
) u_rpwd_checker (.*);
